// ===== src/mvm_pkg.sv =====
// Shared constants, types and control struct for the matrix-vector multiply stream.
// Used by mvm_wmem, mvm_cell and matrix_vector_multiply_stream; no dependencies.
package mvm_pkg;

	localparam int MAX_INNER = 256;
	localparam int MAX_COLS  = 64;
	localparam int DEPTH     = MAX_INNER * MAX_COLS;

	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int INNER_W   = $clog2(MAX_INNER + 1);
	localparam int COLS_W    = $clog2(MAX_COLS + 1);
	localparam int EC_W      = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int CIDX_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	localparam int VALUE_W   = 16;
	localparam int PROD_W    = 32;
	localparam int ACC_W     = 48;
	localparam int COLUMN_W  = 6;
	localparam int ILEN_W    = 9;
	localparam int OCOLS_W   = 7;
	localparam int ROWS_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_DATA_W = 56;

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [ADDR_W:0]      addr_ext_t;
	typedef logic [INNER_W-1:0]   inner_t;
	typedef logic [INNER_W:0]     inner_ext_t;
	typedef logic [COLS_W-1:0]    cols_t;
	typedef logic [EC_W-1:0]      ec_t;
	typedef logic [CIDX_W-1:0]    cidx_t;
	typedef logic [ROWS_W:0]      rows_ext_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_ROW  = 1'b1;

	typedef struct packed {
		logic w_shift;
		logic mul;
		logic acc;
		logic capture;
		logic res_shift;
	} cell_ctl_t;

endpackage

// ===== src/mvm_wmem.sv =====
// Weight store: one write port, one registered read port.
// Depends on mvm_pkg.
module mvm_wmem (
	input  logic                  clk,
	input  logic                  we,
	input  mvm_pkg::addr_t        waddr,
	input  mvm_pkg::value_t       wdata,
	input  logic                  re,
	input  mvm_pkg::addr_t        raddr,
	output mvm_pkg::value_t       rdata
);

	mvm_pkg::value_t mem [mvm_pkg::DEPTH];
	mvm_pkg::value_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/mvm_cell.sv =====
// One column cell: weight shift stage, multiplier, accumulator and result shift stage.
// Depends on mvm_pkg.
module mvm_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mvm_pkg::cell_ctl_t    ctl,
	input  logic                  active,
	input  mvm_pkg::value_t       x,
	input  mvm_pkg::value_t       w_in,
	output mvm_pkg::value_t       w_out,
	input  mvm_pkg::acc_t         res_in,
	output mvm_pkg::acc_t         res_out
);

	mvm_pkg::value_t w_q;
	mvm_pkg::prod_t  prod_q;
	mvm_pkg::acc_t   acc_q;
	mvm_pkg::acc_t   res_q;
	mvm_pkg::acc_t   sum;

	assign sum = acc_q + mvm_pkg::acc_t'(prod_q);

	always_ff @(posedge clk) begin
		if (ctl.w_shift) begin
			w_q <= w_in;
		end
		if (ctl.mul) begin
			prod_q <= x * w_q;
		end
		if (ctl.capture) begin
			res_q <= sum;
		end else if (ctl.res_shift) begin
			res_q <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.capture) begin
			acc_q <= '0;
		end else if (ctl.acc && active) begin
			acc_q <= sum;
		end
	end

	assign w_out   = w_q;
	assign res_out = res_q;

endmodule

// ===== src/matrix_vector_multiply_stream.sv =====
// Top level: config registers, sequencer, weight store and chain of column cells.
// Depends on mvm_pkg, mvm_wmem, mvm_cell.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser: opcode; tdata[15:0]: value
//  m_axis    out  tvalid/tready          tdata: result_value, column; tlast; tuser: matrix_end
//  cfg       in   cfg_we                 cfg_index, cfg_data
//
// A weight load is written into the weight store as it is accepted. For a row element the
// single weight store read port fetches one column weight per cycle into the cell chain,
// then the element is multiplied and accumulated; s_axis stays not ready until it is done.
// A row's last element waits in its accumulate step while the previous row's results drain.
// Reset clears counters, accumulators and config to their defaults.
module matrix_vector_multiply_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] value
	input  logic        s_axis_tuser,   // [0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [47:0] result_value, [53:48] column, [55:54] zero
	output logic        m_axis_tlast,
	output logic        m_axis_tuser,   // [0] matrix_end
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FETCH = 5'b00010,
		S_WAIT  = 5'b00100,
		S_MUL   = 5'b01000,
		S_ACC   = 5'b10000
	} state_t;

	state_t state_q;

	logic [mvm_pkg::ILEN_W-1:0]  inner_len_q;
	logic [mvm_pkg::OCOLS_W-1:0] out_cols_q;
	logic [mvm_pkg::ROWS_W-1:0]  rows_q;

	mvm_pkg::inner_t  inner_eff;
	mvm_pkg::cols_t   cols_eff;
	logic [mvm_pkg::ROWS_W-1:0] rows_eff;

	mvm_pkg::ec_t     ec_q;
	logic [mvm_pkg::ROWS_W-1:0] rc_q;
	mvm_pkg::addr_t   ptr_q;
	mvm_pkg::addr_t   addr_q;
	mvm_pkg::cidx_t   fcnt_q;
	mvm_pkg::value_t  x_q;
	logic             row_end_q;
	logic             end_q;
	logic             rd_s1;
	mvm_pkg::cols_t   out_cnt_q;
	mvm_pkg::cidx_t   out_col_q;
	logic             out_end_q;

	logic             in_req;
	logic             load_req;
	logic             row_req;
	logic             out_req;
	logic             row_end;
	logic             end_matrix;
	mvm_pkg::addr_ext_t ptr_next;
	mvm_pkg::addr_ext_t limit;
	mvm_pkg::addr_ext_t base;
	mvm_pkg::value_t  rdata;
	mvm_pkg::cell_ctl_t ctl;

	mvm_pkg::value_t  w_chain   [mvm_pkg::MAX_COLS];
	mvm_pkg::acc_t    res_chain [mvm_pkg::MAX_COLS];

	// effective register values
	always_comb begin
		inner_eff = mvm_pkg::inner_t'(inner_len_q);
		if (inner_len_q == '0) begin
			inner_eff = mvm_pkg::inner_t'(1);
		end else if (int'(inner_len_q) > mvm_pkg::MAX_INNER) begin
			inner_eff = mvm_pkg::inner_t'(mvm_pkg::MAX_INNER);
		end
		cols_eff = mvm_pkg::cols_t'(out_cols_q);
		if (out_cols_q == '0) begin
			cols_eff = mvm_pkg::cols_t'(1);
		end else if (int'(out_cols_q) > mvm_pkg::MAX_COLS) begin
			cols_eff = mvm_pkg::cols_t'(mvm_pkg::MAX_COLS);
		end
		rows_eff = (rows_q == '0) ? mvm_pkg::ROWS_W'(1) : rows_q;
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_req   = s_axis_tvalid && s_axis_tready;
	assign load_req = in_req && (s_axis_tuser == mvm_pkg::OP_LOAD);
	assign row_req  = in_req && (s_axis_tuser == mvm_pkg::OP_ROW);
	assign out_req  = m_axis_tvalid && m_axis_tready;

	assign row_end    = (mvm_pkg::inner_ext_t'(ec_q) + 1'b1) >= mvm_pkg::inner_ext_t'(inner_eff);
	assign end_matrix = (mvm_pkg::rows_ext_t'(rc_q) + 1'b1) >= mvm_pkg::rows_ext_t'(rows_eff);
	assign ptr_next   = mvm_pkg::addr_ext_t'(ptr_q) + 1'b1;
	assign limit      = mvm_pkg::addr_ext_t'(inner_eff * cols_eff);
	assign base       = mvm_pkg::addr_ext_t'((cols_eff - 1'b1) * inner_eff)
	                  + mvm_pkg::addr_ext_t'(ec_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_len_q <= mvm_pkg::ILEN_W'(mvm_pkg::MAX_INNER);
			out_cols_q  <= mvm_pkg::OCOLS_W'(mvm_pkg::MAX_COLS);
			rows_q      <= mvm_pkg::ROWS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				mvm_pkg::CFG_INNER_LEN:   inner_len_q <= cfg_data[mvm_pkg::ILEN_W-1:0];
				mvm_pkg::CFG_OUT_COLS:    out_cols_q  <= cfg_data[mvm_pkg::OCOLS_W-1:0];
				mvm_pkg::CFG_ROWS_IN_USE: rows_q      <= cfg_data[mvm_pkg::ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ctl           = '0;
		ctl.w_shift   = rd_s1;
		ctl.mul       = (state_q == S_MUL);
		ctl.acc       = (state_q == S_ACC) && !row_end_q;
		ctl.capture   = (state_q == S_ACC) && row_end_q && (out_cnt_q == '0);
		ctl.res_shift = out_req;
	end

	always_ff @(posedge clk) begin
		if (row_req) begin
			x_q <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ec_q      <= '0;
			rc_q      <= '0;
			ptr_q     <= '0;
			addr_q    <= '0;
			fcnt_q    <= '0;
			row_end_q <= 1'b0;
			end_q     <= 1'b0;
			rd_s1     <= 1'b0;
			out_cnt_q <= '0;
			out_col_q <= '0;
			out_end_q <= 1'b0;
		end else begin
			rd_s1 <= (state_q == S_FETCH);
			if (load_req) begin
				ptr_q <= (ptr_next >= limit) ? '0 : ptr_next[mvm_pkg::ADDR_W-1:0];
			end
			case (state_q)
				S_IDLE: begin
					if (row_req) begin
						addr_q    <= base[mvm_pkg::ADDR_W-1:0];
						fcnt_q    <= mvm_pkg::cidx_t'(cols_eff - 1'b1);
						row_end_q <= row_end;
						end_q     <= end_matrix;
						if (row_end) begin
							ec_q <= '0;
							rc_q <= end_matrix ? '0 : rc_q + 1'b1;
						end else begin
							ec_q <= ec_q + 1'b1;
						end
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					addr_q <= addr_q - mvm_pkg::addr_t'(inner_eff);
					fcnt_q <= fcnt_q - 1'b1;
					if (fcnt_q == '0) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: state_q <= S_MUL;
				S_MUL:  state_q <= S_ACC;
				S_ACC: begin
					if (!row_end_q || ctl.capture) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (ctl.capture) begin
				out_cnt_q <= cols_eff;
				out_col_q <= '0;
				out_end_q <= end_q;
			end else if (out_req) begin
				out_cnt_q <= out_cnt_q - 1'b1;
				out_col_q <= out_col_q + 1'b1;
			end
		end
	end

	mvm_wmem u_wmem (
		.clk   (clk),
		.we    (load_req),
		.waddr (ptr_q),
		.wdata (s_axis_tdata),
		.re    (state_q == S_FETCH),
		.raddr (addr_q),
		.rdata (rdata)
	);

	for (genvar k = 0; k < mvm_pkg::MAX_COLS; k++) begin : g_cell
		mvm_pkg::value_t w_prev;
		mvm_pkg::acc_t   res_next;
		if (k == 0) begin : g_head
			assign w_prev = rdata;
		end else begin : g_body
			assign w_prev = w_chain[k-1];
		end
		if (k == mvm_pkg::MAX_COLS - 1) begin : g_tail
			assign res_next = '0;
		end else begin : g_mid
			assign res_next = res_chain[k+1];
		end
		mvm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.active  (cols_eff > mvm_pkg::cols_t'(k)),
			.x       (x_q),
			.w_in    (w_prev),
			.w_out   (w_chain[k]),
			.res_in  (res_next),
			.res_out (res_chain[k])
		);
	end

	assign m_axis_tvalid = (out_cnt_q != '0);
	assign m_axis_tlast  = (out_cnt_q == mvm_pkg::cols_t'(1));
	assign m_axis_tuser  = m_axis_tlast && out_end_q;
	assign m_axis_tdata  = {2'b00, mvm_pkg::COLUMN_W'(out_col_q), res_chain[0]};

endmodule
